// ----- sv/hbfl_pkg.sv -----
package hbfl_pkg;

  localparam int P_NUM_BUFFERS       = 256;
  localparam int P_NUM_USERS         = 1024;
  localparam int P_MAX_HARQ_PER_USER = 16;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_LIST_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_DEALLOC = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_SETF    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_USED   = 2'd1,
    ST_NOLIST = 2'd2,
    ST_NOBUF  = 2'd3
  } resp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SWEEP,
    OP_LOAD,
    OP_SETF,
    OP_RD_USER,
    OP_REL_INIT,
    OP_REL_RD,
    OP_REL_PUSH,
    OP_REL_END,
    OP_NEXT_U,
    OP_TAKE_INIT,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_FLAG_RD,
    OP_GRAB,
    OP_SH_RD,
    OP_SH_WR,
    OP_SH_END,
    OP_RB_INIT,
    OP_RB_PUSH,
    OP_COMMIT,
    OP_EMIT,
    OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    resp_t  st;
  } ctl_cmd_t;

  typedef struct packed {
    logic      sweep_done;
    logic      rebuild;
    logic      holds;
    logic      rel_more;
    logic      last_user;
    logic      take_more;
    logic      pos_zero;
    logic      flag_busy;
    logic      sh_more;
    logic      rb_more;
    logic      emit_last;
    logic      n_zero;
    logic      out_free;
    logic      user_oor;
    logic      over_lim;
    cmd_code_t cmd;
  } dp_stat_t;

endpackage

// ----- sv/hbfl_if.sv -----
interface hbfl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [9:0] user_index;
  logic [4:0] harq_count;
  logic [7:0] buffer_id;
  logic       busy_flag;

  modport source (output valid, command, user_index, harq_count, buffer_id, busy_flag,
                  input ready);
  modport sink (input valid, command, user_index, harq_count, buffer_id, busy_flag,
                output ready);
endinterface

interface hbfl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] granted_buffer;
  logic       last;

  modport source (output valid, status, granted_buffer, last, input ready);
  modport sink (input valid, status, granted_buffer, last, output ready);
endinterface

// ----- sv/hbfl_dp.sv -----
module hbfl_dp import hbfl_pkg::*; #(
  parameter int NUM_BUFFERS       = P_NUM_BUFFERS,
  parameter int NUM_USERS         = P_NUM_USERS,
  parameter int MAX_HARQ_PER_USER = P_MAX_HARQ_PER_USER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            in_command,
  input  logic [9:0]            in_user_index,
  input  logic [4:0]            in_harq_count,
  input  logic [7:0]            in_buffer_id,
  input  logic                  in_busy_flag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [7:0]            out_granted_buffer,
  output logic                  out_last,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat
);

  localparam int BW    = $clog2(NUM_BUFFERS);
  localparam int CW    = $clog2(NUM_BUFFERS + 1);
  localparam int UW    = $clog2(NUM_USERS);
  localparam int LW    = $clog2(NUM_USERS + 1);
  localparam int KW    = $clog2(MAX_HARQ_PER_USER + 1);
  localparam int KIW   = (MAX_HARQ_PER_USER > 1) ? $clog2(MAX_HARQ_PER_USER) : 1;
  localparam int DEPTH = NUM_USERS * MAX_HARQ_PER_USER;
  localparam int AW    = $clog2(DEPTH);
  localparam int SL    = (NUM_BUFFERS > NUM_USERS) ? NUM_BUFFERS : NUM_USERS;
  localparam int SWW   = $clog2(SL);
  localparam int CNT_RST = (NUM_BUFFERS < 256) ? NUM_BUFFERS : 256;
  localparam int LIM_RST = (NUM_USERS < 1024) ? NUM_USERS : 1024;

  // memories
  logic [BW-1:0] fo_mem [NUM_BUFFERS];
  logic          if_mem [NUM_BUFFERS];
  logic          uh_mem [NUM_USERS];
  logic [KW-1:0] ut_mem [NUM_USERS];
  logic [BW-1:0] ub_mem [DEPTH];

  logic [BW-1:0] fo_q_r;
  logic          if_q_r;
  logic          uh_q_r;
  logic [KW-1:0] ut_q_r;
  logic [BW-1:0] ub_q_r;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  lim_r, lim_nxt;
  logic [CW-1:0]  ft_r;
  logic [LW-1:0]  lists_r;
  logic [SWW-1:0] sweep_r;

  cmd_code_t     cmd_r;
  logic [UW-1:0] cu_r;
  logic          user_oor_r;
  logic [KW-1:0] want_r;
  logic [BW-1:0] bid_r;
  logic          bid_oor_r;
  logic          busy_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] j_r;
  logic [KW-1:0] n_r;
  logic [KW-1:0] k_r;
  logic [KW-1:0] nr_r;
  logic [BW-1:0] taken_r [MAX_HARQ_PER_USER];

  logic       out_valid_r;
  resp_t      out_status_r;
  logic [7:0] out_buf_r;
  logic       out_last_r;

  logic          rebuild;
  logic          push_en;
  logic [BW-1:0] push_b;
  logic          fo_we;
  logic [BW-1:0] fo_wa;
  logic [BW-1:0] fo_wd;
  logic          fo_re;
  logic [BW-1:0] fo_ra;
  logic [AW-1:0] ub_base;
  logic          emit_last;

  assign rebuild   = cfg_we && (cfg_index == REG_BUFFER_COUNT);
  assign ub_base   = AW'(cu_r) * AW'(MAX_HARQ_PER_USER);
  assign emit_last = (32'(k_r) + 1 == 32'(n_r));

  // saturate register writes
  always_comb begin
    if (cfg_data[8:0] == 9'd0) begin
      cnt_nxt = CW'(1);
    end else if (32'(cfg_data[8:0]) > NUM_BUFFERS) begin
      cnt_nxt = CW'(NUM_BUFFERS);
    end else begin
      cnt_nxt = CW'(cfg_data[8:0]);
    end
    if (cfg_data[10:0] == 11'd0) begin
      lim_nxt = LW'(1);
    end else if (32'(cfg_data[10:0]) > NUM_USERS) begin
      lim_nxt = LW'(NUM_USERS);
    end else begin
      lim_nxt = LW'(cfg_data[10:0]);
    end
  end

  // push to the back of the free list
  always_comb begin
    push_en = 1'b0;
    push_b  = ub_q_r;
    if (cmd.op == OP_REL_PUSH) begin
      push_en = 32'(ft_r) < NUM_BUFFERS;
    end else if (cmd.op == OP_RB_PUSH) begin
      push_en = 32'(ft_r) < NUM_BUFFERS;
      push_b  = taken_r[k_r[KIW-1:0]];
    end
  end

  // free list port mux
  always_comb begin
    fo_we = 1'b0;
    fo_wa = ft_r[BW-1:0];
    fo_wd = push_b;
    fo_re = 1'b0;
    fo_ra = BW'(32'(pos_r) - 1);
    case (cmd.op)
      OP_SWEEP: begin
        fo_we = 32'(sweep_r) < NUM_BUFFERS;
        fo_wa = sweep_r[BW-1:0];
        fo_wd = (32'(sweep_r) < 32'(cnt_r)) ? sweep_r[BW-1:0] : '0;
      end
      OP_REL_PUSH, OP_RB_PUSH: fo_we = push_en;
      OP_SH_WR: begin
        fo_we = 1'b1;
        fo_wa = j_r[BW-1:0];
        fo_wd = fo_q_r;
      end
      OP_SCAN_RD: fo_re = 1'b1;
      OP_SH_RD: begin
        fo_re = 1'b1;
        fo_ra = BW'(32'(j_r) + 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fo_we) fo_mem[fo_wa] <= fo_wd;
    if (fo_re) fo_q_r <= fo_mem[fo_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SWEEP && 32'(sweep_r) < NUM_BUFFERS) begin
      if_mem[sweep_r[BW-1:0]] <= 1'b0;
    end else if (cmd.op == OP_SETF && !bid_oor_r) begin
      if_mem[bid_r] <= busy_r;
    end
    if (cmd.op == OP_FLAG_RD) if_q_r <= if_mem[fo_q_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SWEEP && 32'(sweep_r) < NUM_USERS) begin
      uh_mem[sweep_r[UW-1:0]] <= 1'b0;
    end else if (cmd.op == OP_REL_END) begin
      uh_mem[cu_r] <= 1'b0;
    end else if (cmd.op == OP_COMMIT) begin
      uh_mem[cu_r] <= 1'b1;
    end
    if (cmd.op == OP_RD_USER) uh_q_r <= uh_mem[cu_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) ut_mem[cu_r] <= n_r;
    if (cmd.op == OP_RD_USER) ut_q_r <= ut_mem[cu_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_GRAB) ub_mem[ub_base + AW'(n_r)] <= fo_q_r;
    if (cmd.op == OP_REL_RD) ub_q_r <= ub_mem[ub_base + AW'(k_r)];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CW'(CNT_RST);
      lim_r       <= LW'(LIM_RST);
      ft_r        <= CW'(CNT_RST);
      lists_r     <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rebuild) begin
        cnt_r   <= cnt_nxt;
        ft_r    <= cnt_nxt;
        lists_r <= '0;
        sweep_r <= '0;
      end else begin
        if (cmd.op == OP_SWEEP && 32'(sweep_r) != SL - 1) sweep_r <= sweep_r + 1'b1;
        if (push_en) ft_r <= ft_r + 1'b1;
        else if (cmd.op == OP_SH_END) ft_r <= ft_r - 1'b1;
        if (cmd.op == OP_REL_END && lists_r != '0) lists_r <= lists_r - 1'b1;
        else if (cmd.op == OP_COMMIT) lists_r <= lists_r + 1'b1;
      end
      if (cfg_we && cfg_index == REG_USER_LIST_LIMIT) lim_r <= lim_nxt;
      if (cmd.op == OP_EMIT || cmd.op == OP_RESP) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r      <= cmd_code_t'(in_command);
        cu_r       <= (cmd_code_t'(in_command) == CMD_CLEAR) ? '0 : UW'(in_user_index);
        user_oor_r <= 32'(in_user_index) >= NUM_USERS;
        want_r     <= (32'(in_harq_count) > MAX_HARQ_PER_USER) ?
                      KW'(MAX_HARQ_PER_USER) : KW'(in_harq_count);
        bid_r      <= BW'(in_buffer_id);
        bid_oor_r  <= 32'(in_buffer_id) >= NUM_BUFFERS;
        busy_r     <= in_busy_flag;
      end
      OP_REL_INIT: begin
        k_r  <= '0;
        nr_r <= ut_q_r;
      end
      OP_REL_RD, OP_RB_PUSH: k_r <= k_r + 1'b1;
      OP_NEXT_U:    cu_r <= cu_r + 1'b1;
      OP_TAKE_INIT: n_r <= '0;
      OP_SCAN_INIT: pos_r <= ft_r;
      OP_SCAN_RD:   pos_r <= pos_r - 1'b1;
      OP_GRAB: begin
        taken_r[n_r[KIW-1:0]] <= fo_q_r;
        n_r <= n_r + 1'b1;
        j_r <= pos_r;
      end
      OP_SH_WR:   j_r <= j_r + 1'b1;
      OP_RB_INIT, OP_COMMIT: k_r <= '0;
      OP_EMIT: begin
        out_status_r <= ST_OK;
        out_buf_r    <= 8'(taken_r[k_r[KIW-1:0]]);
        out_last_r   <= emit_last;
        k_r          <= k_r + 1'b1;
      end
      OP_RESP: begin
        out_status_r <= cmd.st;
        out_buf_r    <= '0;
        out_last_r   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_buffer = out_buf_r;
  assign out_last           = out_last_r;

  always_comb begin
    stat.sweep_done = 32'(sweep_r) == SL - 1;
    stat.rebuild    = rebuild;
    stat.holds      = uh_q_r;
    stat.rel_more   = k_r < nr_r;
    stat.last_user  = 32'(cu_r) == NUM_USERS - 1;
    stat.take_more  = n_r < want_r;
    stat.pos_zero   = pos_r == '0;
    stat.flag_busy  = if_q_r;
    stat.sh_more    = (32'(j_r) + 1) < 32'(ft_r);
    stat.rb_more    = k_r < n_r;
    stat.emit_last  = emit_last;
    stat.n_zero     = n_r == '0;
    stat.out_free   = !out_valid_r || out_ready;
    stat.user_oor   = user_oor_r;
    stat.over_lim   = lists_r >= lim_r;
    stat.cmd        = cmd_r;
  end

  a_ft_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ft_r) <= NUM_BUFFERS)
    else $error("free list total above pool depth");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT || cmd.op == OP_RESP) |-> (!out_valid_r || out_ready))
    else $error("result written over one not yet taken");

  a_commit_lists: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COMMIT && !rebuild) |=> lists_r == $past(lists_r) + 1'b1)
    else $error("commit did not take a user list");

endmodule

// ----- sv/hbfl_ctrl.sv -----
module hbfl_ctrl import hbfl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DISP, S_SETF, S_RDU, S_CHK,
    S_RINIT, S_RCHK, S_RRD, S_RPUSH, S_REND, S_NEXTU,
    S_TINIT, S_TCHK, S_SINIT, S_SCHK, S_SRD, S_FRD, S_FCHK,
    S_GRAB, S_HCHK, S_HRD, S_HWR, S_HEND,
    S_RBINIT, S_RBCHK, S_RBPUSH, S_COMMIT, S_EMIT, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  resp_t  st_r, st_nxt;
  dp_op_t op;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    op        = OP_NONE;
    unique case (state_r)
      S_SWEEP: begin
        op = OP_SWEEP;
        if (stat.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = ST_OK;
        unique case (stat.cmd)
          CMD_SETF:    state_nxt = S_SETF;
          CMD_CLEAR:   state_nxt = S_RDU;
          CMD_DEALLOC: state_nxt = stat.user_oor ? S_RESP : S_RDU;
          CMD_ALLOC: begin
            if (stat.user_oor) begin
              st_nxt    = ST_NOLIST;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_RDU;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_SETF: begin
        op        = OP_SETF;
        state_nxt = S_RESP;
      end
      S_RDU: begin
        op        = OP_RD_USER;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.cmd == CMD_ALLOC) begin
          if (stat.holds) begin
            st_nxt    = ST_USED;
            state_nxt = S_RESP;
          end else if (stat.over_lim) begin
            st_nxt    = ST_NOLIST;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_TINIT;
          end
        end else begin
          state_nxt = stat.holds ? S_RINIT : S_NEXTU;
        end
      end
      S_RINIT: begin
        op        = OP_REL_INIT;
        state_nxt = S_RCHK;
      end
      S_RCHK:  state_nxt = stat.rel_more ? S_RRD : S_REND;
      S_RRD: begin
        op        = OP_REL_RD;
        state_nxt = S_RPUSH;
      end
      S_RPUSH: begin
        op        = OP_REL_PUSH;
        state_nxt = S_RCHK;
      end
      S_REND: begin
        op        = OP_REL_END;
        state_nxt = S_NEXTU;
      end
      S_NEXTU: begin
        if (stat.cmd == CMD_CLEAR && !stat.last_user) begin
          op        = OP_NEXT_U;
          state_nxt = S_RDU;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_TINIT: begin
        op        = OP_TAKE_INIT;
        state_nxt = S_TCHK;
      end
      S_TCHK:  state_nxt = stat.take_more ? S_SINIT : S_COMMIT;
      S_SINIT: begin
        op        = OP_SCAN_INIT;
        state_nxt = S_SCHK;
      end
      S_SCHK:  state_nxt = stat.pos_zero ? S_RBINIT : S_SRD;
      S_SRD: begin
        op        = OP_SCAN_RD;
        state_nxt = S_FRD;
      end
      S_FRD: begin
        op        = OP_FLAG_RD;
        state_nxt = S_FCHK;
      end
      S_FCHK:  state_nxt = stat.flag_busy ? S_SCHK : S_GRAB;
      S_GRAB: begin
        op        = OP_GRAB;
        state_nxt = S_HCHK;
      end
      S_HCHK:  state_nxt = stat.sh_more ? S_HRD : S_HEND;
      S_HRD: begin
        op        = OP_SH_RD;
        state_nxt = S_HWR;
      end
      S_HWR: begin
        op        = OP_SH_WR;
        state_nxt = S_HCHK;
      end
      S_HEND: begin
        op        = OP_SH_END;
        state_nxt = S_TCHK;
      end
      S_RBINIT: begin
        op        = OP_RB_INIT;
        state_nxt = S_RBCHK;
      end
      S_RBCHK: begin
        if (stat.rb_more) begin
          state_nxt = S_RBPUSH;
        end else begin
          st_nxt    = ST_NOBUF;
          state_nxt = S_RESP;
        end
      end
      S_RBPUSH: begin
        op        = OP_RB_PUSH;
        state_nxt = S_RBCHK;
      end
      S_COMMIT: begin
        op     = OP_COMMIT;
        st_nxt = ST_OK;
        state_nxt = stat.n_zero ? S_RESP : S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          op = OP_EMIT;
          if (stat.emit_last) state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          op        = OP_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (stat.rebuild) state_nxt = S_SWEEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // no transfer while a pool rebuild is being written
  assign in_ready = (state_r == S_IDLE) && !stat.rebuild;
  assign cmd.op   = op;
  assign cmd.st   = st_r;

endmodule

// ----- sv/harq_buffer_free_list_allocator.sv -----
// an allocate scans the free list from its tail for a buffer whose in-flight flag is clear,
//   then shifts the entries above it down, per granted buffer; clear walks all users
// one command at a time: a new command is taken only when the sequencer is idle
// reset and a buffer_count write start a clearing pass over max(NUM_BUFFERS, NUM_USERS)
//   entries that refills the free list and clears in-flight and user-holds bits
// no transfer is accepted until that pass is done; configuration writes are always taken
module harq_buffer_free_list_allocator import hbfl_pkg::*; #(
  parameter int NUM_BUFFERS       = P_NUM_BUFFERS,
  parameter int NUM_USERS         = P_NUM_USERS,
  parameter int MAX_HARQ_PER_USER = P_MAX_HARQ_PER_USER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hbfl_in_if.sink               in_ch,
  hbfl_out_if.source            out_ch
);

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: one state per memory access step
  hbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: free list, in-flight flags, per-user lists, output register
  hbfl_dp #(
    .NUM_BUFFERS       (NUM_BUFFERS),
    .NUM_USERS         (NUM_USERS),
    .MAX_HARQ_PER_USER (MAX_HARQ_PER_USER)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_command         (in_ch.command),
    .in_user_index      (in_ch.user_index),
    .in_harq_count      (in_ch.harq_count),
    .in_buffer_id       (in_ch.buffer_id),
    .in_busy_flag       (in_ch.busy_flag),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_granted_buffer (out_ch.granted_buffer),
    .out_last           (out_ch.last),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule
